### rtl/two_marker_heading_tracker_unit_defines.svh
// ----------------------------------------------------------------------------
// two_marker_heading_tracker_unit_defines
// Assertion macros for the checker file of the heading tracker.
// ----------------------------------------------------------------------------
`ifndef TWO_MARKER_HEADING_TRACKER_UNIT_DEFINES_SVH
`define TWO_MARKER_HEADING_TRACKER_UNIT_DEFINES_SVH

// Clocked assertion with reset gating.
`define TMHT_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tmht assertion failed");

// Same, on the block's own clock and reset.
`define TMHT_ASSERT(label, prop) \
  `TMHT_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

### rtl/tmht_pkg.sv
// ----------------------------------------------------------------------------
// tmht_pkg
// Types and constants of the two-marker heading tracker.
// ----------------------------------------------------------------------------
package tmht_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DMUL_X,
    ST_DMUL_Y,
    ST_DSQRT,
    ST_ASSIGN,
    ST_HEAD,
    ST_NORM,
    ST_SQX,
    ST_SQY,
    ST_DIV,
    ST_NSQRT,
    ST_SM_A,
    ST_SM_B,
    ST_FINISH
  } state_e;

  localparam logic [3:0]         PAIR_COUNT = 4'd2;
  localparam logic [15:0]        GAIN_RESET = 16'd6554;
  localparam logic signed [15:0] FALLBACK_Y = 16'sd1638;

  localparam int SQRT_STEPS = 25;
  localparam int DIV_STEPS  = 29;

  localparam int MUL_W  = 25;
  localparam int PROD_W = 50;
  localparam int ACC_W  = 42;
  localparam int REM_W  = 36;
  localparam int SRC_W  = 50;
  localparam int ROOT_W = 25;
  localparam int SM_W   = 24;
  localparam int SUM_W  = 26;

endpackage

### rtl/two_marker_heading_tracker_unit.sv
// ----------------------------------------------------------------------------
// two_marker_heading_tracker_unit
// Smoothed heading from two tracked markers, one shared iterative datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one camera frame per
//   transaction: marker count and two marker positions in Q8.8.
//   Output channel (out_valid_o/out_ready_i) returns one smoothed heading
//   per frame in Q2.14.
//   Config channel (cfg_valid_i/cfg_ready_o) writes the smoothing gain;
//   always ready, write only while idle.
//   Steps per frame: a frame without a marker pair goes straight to
//   smoothing; a first pair skips the distance roots; a later pair takes
//   four distance roots to match markers, then, like a first pair, two
//   divisions and two roots (skipped when the markers coincide, preceded by
//   normalize shifts when coordinates are wider than 16 bits). The bit-serial
//   subtract/compare unit computes every square root and division.
//   in_ready_o is high only while the sequencer idles; one frame at a time.
//   The result sits in an output register, so a stalled receiver does not
//   block the next frame; a finished result waits in the last step until
//   the output register frees.
//   Reset clears the tracked points, the pair flag and the smoothed heading,
//   and loads the default gain.
module two_marker_heading_tracker_unit import tmht_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [15:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [3:0]                    marker_count_i,
  input  logic signed [COORD_WIDTH-1:0] first_x_i,
  input  logic signed [COORD_WIDTH-1:0] first_y_i,
  input  logic signed [COORD_WIDTH-1:0] second_x_i,
  input  logic signed [COORD_WIDTH-1:0] second_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [15:0]            heading_x_o,
  output logic signed [15:0]            heading_y_o
);

  localparam int AW = (COORD_WIDTH + 1 > 17) ? COORD_WIDTH + 1 : 17;
  localparam int MW = (COORD_WIDTH > 16) ? COORD_WIDTH : 16;

  function automatic logic signed [15:0] reduce_coord(
    input logic signed [COORD_WIDTH-1:0] c
  );
    logic signed [MW-1:0] e;
    e = MW'(c);
    return 16'(e >>> (MW - 16));
  endfunction

  state_e state_q, state_d;
  logic [15:0] gain_q, gain_d;
  logic signed [COORD_WIDTH-1:0] lpx_q, lpx_d, lpy_q, lpy_d;
  logic signed [COORD_WIDTH-1:0] rpx_q, rpx_d, rpy_q, rpy_d;
  logic had_q, had_d;
  logic signed [SM_W-1:0] sm_x_q, sm_x_d, sm_y_q, sm_y_d;
  logic out_valid_q, out_valid_d;

  logic signed [COORD_WIDTH-1:0] p0x_q, p0x_d, p0y_q, p0y_d;
  logic signed [COORD_WIDTH-1:0] p1x_q, p1x_d, p1y_q, p1y_d;
  logic [SUM_W-1:0] sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic [1:0] dk_q, dk_d;
  logic [4:0] cnt_q, cnt_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [SRC_W-1:0] src_q, src_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [DIV_STEPS-1:0] quo_q, quo_d;
  logic [AW-1:0] ax_q, ax_d, ay_q, ay_d;
  logic dx_pos_q, dx_pos_d, dy_neg_q, dy_neg_d;
  logic [31:0] sqx_q, sqx_d, sqy_q, sqy_d;
  logic [32:0] s_q, s_d;
  logic comp_q, comp_d;
  logic signed [15:0] raw_x_q, raw_x_d, raw_y_q, raw_y_d;
  logic signed [15:0] hx_q, hx_d, hy_q, hy_d;

  // Shared multiplier and subtract/compare unit
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [REM_W-1:0]         sub_a, sub_b;
  logic [REM_W:0]           diff;
  logic                     sub_ge;

  assign prod   = mul_a * mul_b;
  assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge = ~diff[REM_W];

  logic signed [COORD_WIDTH-1:0] pa_x, pa_y, pb_x, pb_y;
  logic signed [16:0] ddx, ddy;
  logic signed [AW-1:0] hdx, hdy;
  logic [REM_W-1:0] sq_remx, sq_trial, div_remx;
  logic [31:0] div_num;
  logic div_bit;
  logic [ROOT_W-1:0] root_nxt;
  logic [DIV_STEPS-1:0] quo_nxt;
  logic signed [ACC_W-1:0] d2, sm_sum;
  logic signed [15:0] raw_sel, mag;
  logic signed [SM_W-1:0] raw_sh, old_sel, sm_new;
  logic big, pair;

  always_comb begin
    pa_x = dk_q[0] ? rpx_q : lpx_q;
    pa_y = dk_q[0] ? rpy_q : lpy_q;
    pb_x = (dk_q[1] ^ dk_q[0]) ? p1x_q : p0x_q;
    pb_y = (dk_q[1] ^ dk_q[0]) ? p1y_q : p0y_q;
    ddx  = 17'(reduce_coord(pa_x)) - 17'(reduce_coord(pb_x));
    ddy  = 17'(reduce_coord(pa_y)) - 17'(reduce_coord(pb_y));
    hdx  = AW'(lpx_q) - AW'(rpx_q);
    hdy  = AW'(lpy_q) - AW'(rpy_q);
    big  = (|ax_q[AW-1:16]) | (|ay_q[AW-1:16]);

    sq_remx  = {rem_q[REM_W-3:0], src_q[SRC_W-1 -: 2]};
    sq_trial = REM_W'({root_q, 2'b01});
    div_num  = comp_q ? sqx_q : sqy_q;
    div_bit  = (cnt_q == '0) ? div_num[0] : 1'b0;
    div_remx = {rem_q[REM_W-2:0], div_bit};

    // the divider and the square root share one subtractor
    if (state_q == ST_DIV) begin
      sub_a = div_remx;
      sub_b = REM_W'(s_q);
    end else begin
      sub_a = sq_remx;
      sub_b = sq_trial;
    end

    raw_sel = comp_q ? raw_y_q : raw_x_q;
    raw_sh  = {raw_sel, 8'b0};
    old_sel = comp_q ? sm_y_q : sm_x_q;
    pair    = (marker_count_i == PAIR_COUNT);
  end

  always_comb begin
    state_d     = state_q;
    gain_d      = gain_q;
    lpx_d       = lpx_q;
    lpy_d       = lpy_q;
    rpx_d       = rpx_q;
    rpy_d       = rpy_q;
    had_d       = had_q;
    sm_x_d      = sm_x_q;
    sm_y_d      = sm_y_q;
    out_valid_d = out_valid_q;
    p0x_d       = p0x_q;
    p0y_d       = p0y_q;
    p1x_d       = p1x_q;
    p1y_d       = p1y_q;
    sum_a_d     = sum_a_q;
    sum_b_d     = sum_b_q;
    dk_d        = dk_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    src_d       = src_q;
    root_d      = root_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    dx_pos_d    = dx_pos_q;
    dy_neg_d    = dy_neg_q;
    sqx_d       = sqx_q;
    sqy_d       = sqy_q;
    s_d         = s_q;
    comp_d      = comp_q;
    raw_x_d     = raw_x_q;
    raw_y_d     = raw_y_q;
    hx_d        = hx_q;
    hy_d        = hy_q;
    mul_a       = '0;
    mul_b       = '0;
    root_nxt    = {root_q[ROOT_W-2:0], sub_ge};
    quo_nxt     = {quo_q[DIV_STEPS-2:0], sub_ge};
    d2          = '0;
    sm_sum      = '0;
    sm_new      = '0;
    mag         = 16'(root_nxt);
    in_ready_o  = (state_q == ST_IDLE);

    if (cfg_valid_i) begin
      gain_d = cfg_data_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          p0x_d   = first_x_i;
          p0y_d   = first_y_i;
          p1x_d   = second_x_i;
          p1y_d   = second_y_i;
          had_d   = pair;
          sum_a_d = '0;
          sum_b_d = '0;
          dk_d    = '0;
          comp_d  = 1'b0;
          raw_x_d = '0;
          raw_y_d = FALLBACK_Y;
          if (!pair) begin
            state_d = ST_SM_A;
          end else if (had_q) begin
            state_d = ST_DMUL_X;
          end else begin
            state_d = ST_ASSIGN;
          end
        end
      end
      ST_DMUL_X: begin
        mul_a   = MUL_W'(ddx);
        mul_b   = MUL_W'(ddx);
        acc_d   = ACC_W'(prod);
        state_d = ST_DMUL_Y;
      end
      ST_DMUL_Y: begin
        mul_a   = MUL_W'(ddy);
        mul_b   = MUL_W'(ddy);
        d2      = acc_q + ACC_W'(prod);
        src_d   = {d2[33:0], 16'b0};
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = '0;
        state_d = ST_DSQRT;
      end
      ST_DSQRT: begin
        rem_d  = sub_ge ? diff[REM_W-1:0] : sq_remx;
        root_d = root_nxt;
        src_d  = {src_q[SRC_W-3:0], 2'b00};
        if (cnt_q == 5'(SQRT_STEPS - 1)) begin
          if (dk_q[1]) begin
            sum_b_d = sum_b_q + SUM_W'(root_nxt);
          end else begin
            sum_a_d = sum_a_q + SUM_W'(root_nxt);
          end
          dk_d    = dk_q + 2'd1;
          state_d = (dk_q == 2'd3) ? ST_ASSIGN : ST_DMUL_X;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_ASSIGN: begin
        // keep marker 0 on the left only if that costs strictly less
        if (sum_a_q < sum_b_q) begin
          lpx_d = p0x_q;
          lpy_d = p0y_q;
          rpx_d = p1x_q;
          rpy_d = p1y_q;
        end else begin
          lpx_d = p1x_q;
          lpy_d = p1y_q;
          rpx_d = p0x_q;
          rpy_d = p0y_q;
        end
        state_d = ST_HEAD;
      end
      ST_HEAD: begin
        ax_d     = hdx[AW-1] ? AW'(-hdx) : AW'(hdx);
        ay_d     = hdy[AW-1] ? AW'(-hdy) : AW'(hdy);
        dx_pos_d = !hdx[AW-1] && (hdx != '0);
        dy_neg_d = hdy[AW-1];
        state_d  = ST_NORM;
      end
      ST_NORM: begin
        if (big) begin
          ax_d = ax_q >> 1;
          ay_d = ay_q >> 1;
        end else if (ax_q == '0 && ay_q == '0) begin
          // coincident points: keep the fallback heading
          state_d = ST_SM_A;
        end else begin
          state_d = ST_SQX;
        end
      end
      ST_SQX: begin
        mul_a   = MUL_W'({1'b0, ax_q[15:0]});
        mul_b   = MUL_W'({1'b0, ax_q[15:0]});
        sqx_d   = prod[31:0];
        state_d = ST_SQY;
      end
      ST_SQY: begin
        mul_a   = MUL_W'({1'b0, ay_q[15:0]});
        mul_b   = MUL_W'({1'b0, ay_q[15:0]});
        sqy_d   = prod[31:0];
        s_d     = {1'b0, sqx_q} + {1'b0, prod[31:0]};
        rem_d   = REM_W'(prod[31:1]);
        quo_d   = '0;
        cnt_d   = '0;
        comp_d  = 1'b0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = sub_ge ? diff[REM_W-1:0] : div_remx;
        quo_d = quo_nxt;
        if (cnt_q == 5'(DIV_STEPS - 1)) begin
          src_d   = SRC_W'(quo_nxt);
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = '0;
          state_d = ST_NSQRT;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_NSQRT: begin
        rem_d  = sub_ge ? diff[REM_W-1:0] : sq_remx;
        root_d = root_nxt;
        src_d  = {src_q[SRC_W-3:0], 2'b00};
        if (cnt_q == 5'(SQRT_STEPS - 1)) begin
          if (!comp_q) begin
            raw_x_d = dy_neg_q ? -mag : mag;
            comp_d  = 1'b1;
            rem_d   = REM_W'(sqx_q[31:1]);
            quo_d   = '0;
            cnt_d   = '0;
            state_d = ST_DIV;
          end else begin
            raw_y_d = dx_pos_q ? -mag : mag;
            comp_d  = 1'b0;
            state_d = ST_SM_A;
          end
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_SM_A: begin
        mul_a   = MUL_W'({1'b0, gain_q});
        mul_b   = MUL_W'(raw_sh);
        acc_d   = ACC_W'(prod);
        state_d = ST_SM_B;
      end
      ST_SM_B: begin
        mul_a  = MUL_W'(17'h10000 - {1'b0, gain_q});
        mul_b  = MUL_W'(old_sel);
        sm_sum = acc_q + ACC_W'(prod) + ACC_W'(32768);
        sm_new = SM_W'(sm_sum >>> 16);
        if (comp_q) begin
          sm_y_d  = sm_new;
          comp_d  = 1'b0;
          state_d = ST_FINISH;
        end else begin
          sm_x_d  = sm_new;
          comp_d  = 1'b1;
          state_d = ST_SM_A;
        end
      end
      ST_FINISH: begin
        // hold until the output register frees
        if (!out_valid_q || out_ready_i) begin
          hx_d        = 16'((25'(sm_x_q) + 25'sd128) >>> 8);
          hy_d        = 16'((25'(sm_y_q) + 25'sd128) >>> 8);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gain_q      <= GAIN_RESET;
      lpx_q       <= '0;
      lpy_q       <= '0;
      rpx_q       <= '0;
      rpy_q       <= '0;
      had_q       <= 1'b0;
      sm_x_q      <= '0;
      sm_y_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gain_q      <= gain_d;
      lpx_q       <= lpx_d;
      lpy_q       <= lpy_d;
      rpx_q       <= rpx_d;
      rpy_q       <= rpy_d;
      had_q       <= had_d;
      sm_x_q      <= sm_x_d;
      sm_y_q      <= sm_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p0x_q    <= p0x_d;
    p0y_q    <= p0y_d;
    p1x_q    <= p1x_d;
    p1y_q    <= p1y_d;
    sum_a_q  <= sum_a_d;
    sum_b_q  <= sum_b_d;
    dk_q     <= dk_d;
    cnt_q    <= cnt_d;
    acc_q    <= acc_d;
    src_q    <= src_d;
    root_q   <= root_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    ax_q     <= ax_d;
    ay_q     <= ay_d;
    dx_pos_q <= dx_pos_d;
    dy_neg_q <= dy_neg_d;
    sqx_q    <= sqx_d;
    sqy_q    <= sqy_d;
    s_q      <= s_d;
    comp_q   <= comp_d;
    raw_x_q  <= raw_x_d;
    raw_y_q  <= raw_y_d;
    hx_q     <= hx_d;
    hy_q     <= hy_d;
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign heading_x_o = hx_q;
  assign heading_y_o = hy_q;

endmodule

### rtl/tmht_checker.sv
// ----------------------------------------------------------------------------
// tmht_checker
// Port-level checks of the heading tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "two_marker_heading_tracker_unit_defines.svh"

module tmht_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] heading_x_o,
  input logic [15:0] heading_y_o
);

  // a stalled result stays offered
  `TMHT_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o)
  // and keeps its value
  `TMHT_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(heading_x_o) && $stable(heading_y_o))
  // one frame at a time: busy right after an accepted transaction
  `TMHT_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o)
  // a new result appears only as the sequencer returns to idle
  `TMHT_ASSERT(a_idle_on_result, $rose(out_valid_o) |-> in_ready_o)

endmodule

bind two_marker_heading_tracker_unit tmht_checker u_tmht_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .heading_x_o (heading_x_o),
  .heading_y_o (heading_y_o)
);

### tb/sv/two_marker_heading_tracker_unit_tb.sv
// ----------------------------------------------------------------------------
// two_marker_heading_tracker_unit_tb
// Drives random and directed camera frames with random idling on both sides,
// predicts the smoothed heading in fixed point and checks every result.
// ----------------------------------------------------------------------------

class heading_scoreboard;
  logic [15:0]        gain;
  logic signed [15:0] left_x, left_y, right_x, right_y;
  bit                 had_pair;
  longint             sm_x, sm_y;
  logic signed [15:0] exp_x_q[$];
  logic signed [15:0] exp_y_q[$];
  int                 errors;
  int                 checked;

  function new();
    gain = tmht_pkg::GAIN_RESET;
    left_x = 0; left_y = 0; right_x = 0; right_y = 0;
    had_pair = 0; sm_x = 0; sm_y = 0; errors = 0; checked = 0;
  endfunction

  static function longint fshr(longint v, int n);
    return v >>> n;
  endfunction

  static function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  static function longint unsigned span(longint ax, longint ay, longint bx, longint by);
    longint dx, dy;
    dx = ax - bx;
    dy = ay - by;
    return int_sqrt((dx * dx + dy * dy) << 16);
  endfunction

  function longint blend(longint old, longint raw);
    longint g;
    g = gain;
    return fshr(g * (raw * 256) + (65536 - g) * old + 32768, 16);
  endfunction

  function void note_frame(logic [3:0] cnt, logic signed [15:0] f_x, logic signed [15:0] f_y,
                           logic signed [15:0] s_x, logic signed [15:0] s_y);
    longint raw_x, raw_y, dx, dy;
    longint unsigned ax, ay, s, a, b;
    bit pair, zero_left;
    raw_x = 0;
    raw_y = tmht_pkg::FALLBACK_Y;
    pair = (cnt == tmht_pkg::PAIR_COUNT);
    if (pair) begin
      zero_left = 0;
      if (had_pair) begin
        a = span(left_x, left_y, f_x, f_y) + span(right_x, right_y, s_x, s_y);
        b = span(left_x, left_y, s_x, s_y) + span(right_x, right_y, f_x, f_y);
        zero_left = a < b;
      end
      if (zero_left) begin
        left_x = f_x; left_y = f_y; right_x = s_x; right_y = s_y;
      end else begin
        left_x = s_x; left_y = s_y; right_x = f_x; right_y = f_y;
      end
      dx = longint'(left_x) - longint'(right_x);
      dy = longint'(left_y) - longint'(right_y);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      while (ax >= 65536 || ay >= 65536) begin
        ax >>= 1;
        ay >>= 1;
      end
      s = ax * ax + ay * ay;
      if (s != 0) begin
        raw_x = int_sqrt(((ay * ay) << 28) / s);
        raw_y = int_sqrt(((ax * ax) << 28) / s);
        if (dy < 0) raw_x = -raw_x;
        if (dx > 0) raw_y = -raw_y;
      end
    end
    sm_x = blend(sm_x, raw_x);
    sm_y = blend(sm_y, raw_y);
    had_pair = pair;
    exp_x_q.push_back(16'(fshr(sm_x + 128, 8)));
    exp_y_q.push_back(16'(fshr(sm_y + 128, 8)));
  endfunction

  function void check_heading(logic signed [15:0] hx, logic signed [15:0] hy);
    logic signed [15:0] ex, ey;
    if (exp_x_q.size() == 0) begin
      $error("unexpected heading transaction x=%0d y=%0d", hx, hy);
      errors++;
      return;
    end
    ex = exp_x_q.pop_front();
    ey = exp_y_q.pop_front();
    checked++;
    if (hx !== ex) begin
      $error("heading_x expected %0d actual %0d", ex, hx);
      errors++;
    end
    if (hy !== ey) begin
      $error("heading_y expected %0d actual %0d", ey, hy);
      errors++;
    end
  endfunction
endclass

module two_marker_heading_tracker_unit_tb;
  import tmht_pkg::*;

  localparam int RANDOM_FRAMES = 1800;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 300;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic [3:0] marker_count_i = '0;
  logic signed [15:0] first_x_i = '0, first_y_i = '0, second_x_i = '0, second_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic signed [15:0] heading_x_o, heading_y_o;

  heading_scoreboard sb = new();
  bit quiet_phase = 0;
  bit hold_off = 0;
  bit stim_done = 0;
  int idle_cycles = 0;
  int frames_sent = 0;
  int pairs_sent = 0;

  two_marker_heading_tracker_unit dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // idle counter for the watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: sample at the edge, stall in random bursts
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_heading(heading_x_o, heading_y_o);
      if (hold_off) begin
        out_ready_i <= 0;
      end else if (!quiet_phase && out_ready_i && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 7);
        out_ready_i <= 0;
        repeat (gap - 1) begin
          @(posedge clk_i);
          if (out_valid_o && out_ready_i) sb.check_heading(heading_x_o, heading_y_o);
        end
      end else begin
        out_ready_i <= 1;
      end
    end
  end

  task automatic send_frame(logic [3:0] cnt, logic [15:0] fx, logic [15:0] fy,
                            logic [15:0] sx, logic [15:0] sy);
    if (!quiet_phase && $urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    in_valid_i <= 1;
    marker_count_i <= cnt;
    first_x_i <= fx; first_y_i <= fy; second_x_i <= sx; second_y_i <= sy;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_frame(cnt, fx, fy, sx, sy);
    frames_sent++;
    if (cnt == PAIR_COUNT) pairs_sent++;
    in_valid_i <= 0;
    // the block is busy right after an accept; drop valid for that cycle
    @(posedge clk_i);
  endtask

  task automatic write_gain(logic [15:0] g);
    while (sb.exp_x_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1;
    cfg_data_i <= g;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.gain = g;
    cfg_valid_i <= 0;
  endtask

  // well-formed pair: markers near the previous ones, sometimes swapped
  task automatic send_tracked_pair(inout logic [15:0] lx, ly, rx, ry);
    logic [15:0] jit;
    jit = $urandom_range(0, 3) == 0 ? 16'd4000 : 16'd300;
    lx += 16'($urandom_range(0, 2 * jit) - jit);
    ly += 16'($urandom_range(0, 2 * jit) - jit);
    rx += 16'($urandom_range(0, 2 * jit) - jit);
    ry += 16'($urandom_range(0, 2 * jit) - jit);
    if ($urandom_range(0, 1)) send_frame(PAIR_COUNT, lx, ly, rx, ry);
    else send_frame(PAIR_COUNT, rx, ry, lx, ly);
  endtask

  initial begin
    logic [15:0] lx, ly, rx, ry;
    logic [3:0] cnt;
    logic [15:0] gains[4];
    gains = '{16'd0, 16'hFFFF, 16'd32768, 16'd6554};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed frames
    send_frame(4'd0, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF);
    send_frame(PAIR_COUNT, 16'h0100, 16'h0000, 16'hFF00, 16'h0000);
    send_frame(PAIR_COUNT, 16'hFF00, 16'h0010, 16'h0100, 16'h0000);
    send_frame(PAIR_COUNT, 16'h1234, 16'h1234, 16'h1234, 16'h1234);
    send_frame(PAIR_COUNT, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
    send_frame(PAIR_COUNT, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_frame(4'hF, 16'h0, 16'h0, 16'h0, 16'h0);
    send_frame(PAIR_COUNT, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_frame(PAIR_COUNT, 16'h0300, 16'h0000, 16'hFD00, 16'h0000);
    send_frame(PAIR_COUNT, 16'hFD00, 16'h0000, 16'h0300, 16'h0000);
    send_frame(PAIR_COUNT, 16'h0000, 16'h0300, 16'h0000, 16'hFD00);
    send_frame(4'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_frame(4'd3, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);

    // long receiver stall while frames keep coming
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end
      repeat (4) send_frame(PAIR_COUNT, 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom));
    join

    lx = 16'h0800; ly = 16'h0000; rx = 16'hF800; ry = 16'h0000;
    for (int phase = 0; phase < 4; phase++) begin
      write_gain(phase == 3 ? 16'($urandom) : gains[phase]);
      if (phase == 3) quiet_phase = 1;
      for (int i = 0; i < RANDOM_FRAMES / 4; i++) begin
        case ($urandom_range(0, 9))
          0: begin
            cnt = 4'($urandom_range(0, 15));
            send_frame(cnt, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
          end
          1: send_frame(PAIR_COUNT, 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom));
          default: send_tracked_pair(lx, ly, rx, ry);
        endcase
      end
    end
    write_gain(GAIN_RESET);
    stim_done = 1;

    while (sb.exp_x_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Ran %0d frames (%0d with a marker pair), %0d headings checked, five gains.",
             frames_sent, pairs_sent, sb.checked);
    if (sb.errors == 0 && sb.exp_x_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
